### design/timestamped_edge_capture_fifo_unit_defines.svh
// Assertion macros for the timestamped edge capture queue.
// Used by the port checker; expects clk_i and rst_ni in scope.
`ifndef TIMESTAMPED_EDGE_CAPTURE_FIFO_UNIT_DEFINES_SVH
`define TIMESTAMPED_EDGE_CAPTURE_FIFO_UNIT_DEFINES_SVH

// Check a property while out of reset.
`define TECF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check a property that must hold in the cycle after its trigger.
`define TECF_ASSERT_NEXT(lbl, trig, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (prop)) \
    else $error(msg);

`endif

### design/tecf_pkg.sv
// Shared types and constants for the timestamped edge capture queue.
// No dependencies.
package tecf_pkg;

  localparam int unsigned QueueDepth = 64;
  localparam int unsigned IdxW       = $clog2(QueueDepth);
  localparam int unsigned StampW     = 32;
  localparam int unsigned EntryW     = StampW + 2;

  typedef enum logic [2:0] {
    OpEdge  = 3'd0,
    OpPop   = 3'd1,
    OpStart = 3'd2,
    OpStop  = 3'd3,
    OpQuery = 3'd4
  } op_e;

  typedef logic [IdxW-1:0]   idx_t;
  typedef logic [StampW-1:0] stamp_t;

endpackage

### design/tecf_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tecf_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### design/timestamped_edge_capture_fifo_unit.sv
// Capture queue of a two-wire logic analyzer: ring of timestamped SDA/SCL levels.
// Depends on tecf_pkg and tecf_ram.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries one operation per beat:
//   edge event, pop oldest, start capture, stop capture or idle query, with
//   the line levels and the free-running microsecond time now_us_i.
//   Output channel (out_valid_o/out_ready_i) returns exactly one result beat
//   per input beat, in order: found flag, popped levels, stamp and the sticky
//   overflow flag.
//   Pipeline: the edge that accepts an input beat updates the state, loads
//   the middle stage and starts the registered store read; the result
//   register is loaded from the middle stage once the output is free.
//   Throughput: one beat per cycle while results are taken; each op needs at
//   most one access to the one-write, one-read entry store.
//   The ring has QueueDepth slots and holds up to QueueDepth-1 entries.
//   Reset: ring empty, capture off, overflow clear, origin zero; store
//   contents are undefined and are never read before being written.
//   Receiver stall: the result register holds its beat, one more result
//   waits in the middle stage, then in_ready_o drops until the stall clears.
module timestamped_edge_capture_fifo_unit (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [2:0]             op_i,
  input  logic                   sda_i,
  input  logic                   scl_i,
  input  tecf_pkg::stamp_t       now_us_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic                   found_o,
  output logic                   sda_out_o,
  output logic                   scl_out_o,
  output tecf_pkg::stamp_t       stamp_us_o,
  output logic                   overflow_seen_o
);
  import tecf_pkg::*;

  function automatic idx_t advance(input idx_t idx);
    idx_t nxt;
    if (idx == idx_t'(QueueDepth - 1)) begin
      nxt = '0;
    end else begin
      nxt = idx + idx_t'(1);
    end
    return nxt;
  endfunction

  idx_t   wr_idx_q, wr_idx_d;
  idx_t   rd_idx_q, rd_idx_d;
  stamp_t origin_q, origin_d;
  logic   armed_q, armed_d;
  logic   lost_q, lost_d;

  logic   s1_valid_q, s1_valid_d;
  logic   s1_pop_q, s1_pop_d;
  logic   s1_found_q, s1_found_d;
  stamp_t s1_stamp_q, s1_stamp_d;
  logic   s1_ovf_q;

  logic   out_valid_q, out_valid_d;
  logic   found_q, sda_q, scl_q, ovf_q;
  stamp_t stamp_q;

  logic              accept, out_free, out_load;
  logic              ram_we, ram_re;
  logic [EntryW-1:0] ram_wdata, ram_rdata;
  stamp_t            elapsed;
  idx_t              wr_next;

  assign out_free   = !out_valid_q || out_ready_i;
  assign out_load   = s1_valid_q && out_free;
  assign in_ready_o = !s1_valid_q || out_free;
  assign accept     = in_valid_i && in_ready_o;

  assign elapsed   = now_us_i - origin_q;
  assign wr_next   = advance(wr_idx_q);
  assign ram_wdata = {elapsed, scl_i, sda_i};

  always_comb begin
    wr_idx_d   = wr_idx_q;
    rd_idx_d   = rd_idx_q;
    origin_d   = origin_q;
    armed_d    = armed_q;
    lost_d     = lost_q;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    s1_pop_d   = 1'b0;
    s1_found_d = 1'b0;
    s1_stamp_d = '0;
    case (op_e'(op_i))
      OpEdge: begin
        if (armed_q) begin
          if (wr_next == rd_idx_q) begin
            lost_d  = 1'b1;
            armed_d = 1'b0;
          end else begin
            ram_we   = accept;
            wr_idx_d = wr_next;
          end
        end
      end
      OpPop: begin
        if (wr_idx_q != rd_idx_q) begin
          ram_re     = accept;
          s1_pop_d   = 1'b1;
          s1_found_d = 1'b1;
          rd_idx_d   = advance(rd_idx_q);
        end
      end
      OpStart: begin
        wr_idx_d = '0;
        rd_idx_d = '0;
        lost_d   = 1'b0;
        origin_d = now_us_i;
        armed_d  = 1'b1;
      end
      OpStop: begin
        armed_d = 1'b0;
      end
      OpQuery: begin
        s1_stamp_d = elapsed;
        s1_found_d = (wr_idx_q == rd_idx_q);
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (accept) begin
      s1_valid_d = 1'b1;
    end else if (out_load) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_idx_q    <= '0;
      rd_idx_q    <= '0;
      origin_q    <= '0;
      armed_q     <= 1'b0;
      lost_q      <= 1'b0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (accept) begin
        wr_idx_q <= wr_idx_d;
        rd_idx_q <= rd_idx_d;
        origin_q <= origin_d;
        armed_q  <= armed_d;
        lost_q   <= lost_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_pop_q   <= s1_pop_d;
      s1_found_q <= s1_found_d;
      s1_stamp_q <= s1_stamp_d;
      s1_ovf_q   <= lost_d;
    end
    if (out_load) begin
      found_q <= s1_found_q;
      sda_q   <= s1_pop_q & ram_rdata[0];
      scl_q   <= s1_pop_q & ram_rdata[1];
      stamp_q <= s1_pop_q ? ram_rdata[EntryW-1:2] : s1_stamp_q;
      ovf_q   <= s1_ovf_q;
    end
  end

  tecf_ram #(
    .Width (EntryW),
    .Depth (QueueDepth)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wr_idx_q),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (rd_idx_q),
    .rdata_o (ram_rdata)
  );

  assign out_valid_o     = out_valid_q;
  assign found_o         = found_q;
  assign sda_out_o       = sda_q;
  assign scl_out_o       = scl_q;
  assign stamp_us_o      = stamp_q;
  assign overflow_seen_o = ovf_q;

endmodule

### design/tecf_checker.sv
// Port-level checker for the timestamped edge capture queue, bound to the top level.
// Depends on tecf_pkg and timestamped_edge_capture_fifo_unit_defines.svh.
`include "timestamped_edge_capture_fifo_unit_defines.svh"

module tecf_checker (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_ready_o,
  input logic [2:0]       op_i,
  input logic             sda_i,
  input logic             scl_i,
  input tecf_pkg::stamp_t now_us_i,
  input logic             out_valid_o,
  input logic             out_ready_i,
  input logic             found_o,
  input logic             sda_out_o,
  input logic             scl_out_o,
  input tecf_pkg::stamp_t stamp_us_o,
  input logic             overflow_seen_o
);

  `TECF_ASSERT_NEXT(a_out_valid_hold, out_valid_o && !out_ready_i, out_valid_o,
                    "result beat dropped while stalled")

  `TECF_ASSERT_NEXT(a_out_data_hold, out_valid_o && !out_ready_i,
                    $stable(stamp_us_o) && $stable(found_o) && $stable(sda_out_o) &&
                    $stable(scl_out_o) && $stable(overflow_seen_o),
                    "result payload changed while stalled")

  `TECF_ASSERT(a_stall_only_when_full, !in_ready_o |-> out_valid_o,
               "input stalled with no pending result")

  `TECF_ASSERT(a_levels_need_entry,
               out_valid_o && !found_o |-> !sda_out_o && !scl_out_o,
               "line levels reported without a popped entry")

endmodule

bind timestamped_edge_capture_fifo_unit tecf_checker u_tecf_checker (.*);

### tb/sv/timestamped_edge_capture_fifo_unit_checker.sv
// Scoreboard for the timestamped edge capture queue: models the ring, the
// origin, the arm state and the sticky overflow flag, and compares every result.
// Depends on tecf_pkg.
module timestamped_edge_capture_fifo_unit_checker (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_ready_o,
  input  logic [2:0]       op_i,
  input  logic             sda_i,
  input  logic             scl_i,
  input  tecf_pkg::stamp_t now_us_i,
  input  logic             out_valid_o,
  input  logic             out_ready_i,
  input  logic             found_o,
  input  logic             sda_out_o,
  input  logic             scl_out_o,
  input  tecf_pkg::stamp_t stamp_us_o,
  input  logic             overflow_seen_o,
  output int               pending_o,
  output int               errors_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import tecf_pkg::*;

  typedef struct packed {
    logic   found;
    logic   sda;
    logic   scl;
    stamp_t stamp;
    logic   overflow;
  } capture_result_t;

  logic [1:0]      level_mem [QueueDepth];
  stamp_t          stamp_mem [QueueDepth];
  idx_t            wr_ptr;
  idx_t            rd_ptr;
  stamp_t          origin;
  logic            armed;
  logic            lost;
  capture_result_t awaited_results [$];
  int              mismatches;

  assign errors_o = mismatches;

  function automatic idx_t next_slot(idx_t i);
    return (i == idx_t'(QueueDepth - 1)) ? '0 : i + idx_t'(1);
  endfunction

  function automatic capture_result_t ring_step(logic [2:0] op, logic sda, logic scl,
                                                stamp_t now);
    capture_result_t res;
    idx_t            nxt;
    res = '0;
    case (op)
      OpEdge: begin
        if (armed) begin
          nxt = next_slot(wr_ptr);
          if (nxt == rd_ptr) begin
            lost  = 1'b1;
            armed = 1'b0;
          end else begin
            stamp_mem[wr_ptr] = now - origin;
            level_mem[wr_ptr] = {scl, sda};
            wr_ptr            = nxt;
          end
        end
      end
      OpPop: begin
        if (wr_ptr != rd_ptr) begin
          res.found = 1'b1;
          res.sda   = level_mem[rd_ptr][0];
          res.scl   = level_mem[rd_ptr][1];
          res.stamp = stamp_mem[rd_ptr];
          rd_ptr    = next_slot(rd_ptr);
        end
      end
      OpStart: begin
        wr_ptr = '0;
        rd_ptr = '0;
        lost   = 1'b0;
        origin = now;
        armed  = 1'b1;
      end
      OpStop: begin
        armed = 1'b0;
      end
      OpQuery: begin
        res.stamp = now - origin;
        res.found = (wr_ptr == rd_ptr);
      end
      default: begin
      end
    endcase
    res.overflow = lost;
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] checker: %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
    end
  endtask

  initial mismatches = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    capture_result_t want;
    if (!rst_ni) begin
      wr_ptr = '0;
      rd_ptr = '0;
      origin = '0;
      armed  = 1'b0;
      lost   = 1'b0;
      awaited_results.delete();
      pending_o <= 0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        awaited_results.push_back(ring_step(op_i, sda_i, scl_i, now_us_i));
      end
      if (out_valid_o && out_ready_i) begin
        if (awaited_results.size() == 0) begin
          report_mismatch("result beat with no input pending");
        end else begin
          want = awaited_results.pop_front();
          check_field("found", 32'(found_o), 32'(want.found));
          check_field("sda_out", 32'(sda_out_o), 32'(want.sda));
          check_field("scl_out", 32'(scl_out_o), 32'(want.scl));
          check_field("stamp_us", stamp_us_o, want.stamp);
          check_field("overflow_seen", 32'(overflow_seen_o), 32'(want.overflow));
        end
      end
      pending_o <= awaited_results.size();
    end
  end

endmodule

### tb/sv/timestamped_edge_capture_fifo_unit_tb.sv
// Top of the timestamped edge capture queue testbench: clock, reset, operation
// stimulus with bursty sender and stalling receiver, and the verdict.
// Depends on tecf_pkg, the block and timestamped_edge_capture_fifo_unit_checker.
module timestamped_edge_capture_fifo_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tecf_pkg::*;

  localparam int ClkHalf       = 4;
  localparam int ResetCycles   = 10;
  localparam int TargetBeats   = 1250;
  localparam int HoldCycles    = 300;
  localparam int TailCycles    = 8;
  localparam int TimeoutCycles = 400000;

  localparam logic [2:0] OpRsvdLo = 3'd5;
  localparam logic [2:0] OpRsvdHi = 3'd7;

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_ready_o;
  logic [2:0] op_i;
  logic       sda_i;
  logic       scl_i;
  stamp_t     now_us_i;
  logic       out_valid_o;
  logic       out_ready_i;
  logic       found_o;
  logic       sda_out_o;
  logic       scl_out_o;
  stamp_t     stamp_us_o;
  logic       overflow_seen_o;
  int         pending;
  int         mismatches;

  int     beats_sent = 0;
  int     burst_left = 0;
  int     hold_req   = 0;
  stamp_t now_q      = '0;

  always #ClkHalf clk_i = ~clk_i;

  timestamped_edge_capture_fifo_unit u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .op_i            (op_i),
    .sda_i           (sda_i),
    .scl_i           (scl_i),
    .now_us_i        (now_us_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .found_o         (found_o),
    .sda_out_o       (sda_out_o),
    .scl_out_o       (scl_out_o),
    .stamp_us_o      (stamp_us_o),
    .overflow_seen_o (overflow_seen_o)
  );

  timestamped_edge_capture_fifo_unit_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .op_i            (op_i),
    .sda_i           (sda_i),
    .scl_i           (scl_i),
    .now_us_i        (now_us_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .found_o         (found_o),
    .sda_out_o       (sda_out_o),
    .scl_out_o       (scl_out_o),
    .stamp_us_o      (stamp_us_o),
    .overflow_seen_o (overflow_seen_o),
    .pending_o       (pending),
    .errors_o        (mismatches)
  );

  function automatic stamp_t advance_clock();
    case ($urandom_range(0, 9))
      0:       now_q = $urandom;
      1:       now_q = now_q + $urandom;
      default: now_q = now_q + $urandom_range(0, 200);
    endcase
    return now_q;
  endfunction

  task automatic send_beat(input logic [2:0] op, input logic sda, input logic scl,
                           input stamp_t now);
    in_valid_i <= 1'b1;
    op_i       <= op;
    sda_i      <= sda;
    scl_i      <= scl;
    now_us_i   <= now;
    do @(posedge clk_i); while (!in_ready_o);
    beats_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 40);
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
  endtask

  task automatic send_random(input logic [2:0] op);
    send_beat(op, 1'($urandom), 1'($urandom), advance_clock());
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  task automatic fill_session();
    int n_edges;
    int n_pops;
    n_edges = $urandom_range(55, 72);
    n_pops  = $urandom_range(55, 72);
    send_random(OpStart);
    repeat (n_edges) begin
      if ($urandom_range(0, 9) == 0) send_random(OpQuery);
      send_random(OpEdge);
    end
    send_random(OpQuery);
    repeat (n_pops) send_random(OpPop);
  endtask

  task automatic mixed_session(input bit with_start);
    int n_ops;
    int r;
    n_ops = $urandom_range(10, 50);
    if (with_start) send_random(OpStart);
    repeat (n_ops) begin
      r = $urandom_range(0, 99);
      if (r < 45)      send_random(OpEdge);
      else if (r < 80) send_random(OpPop);
      else if (r < 88) send_random(OpQuery);
      else if (r < 92) send_random(OpStop);
      else if (r < 95) send_random(OpStart);
      else             send_random(3'($urandom_range(OpRsvdLo, OpRsvdHi)));
    end
  endtask

  initial begin
    int hold_served;
    int run_left;
    int mode;
    hold_served = 0;
    run_left    = 0;
    mode        = 0;
    out_ready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req != hold_served) begin
        hold_served++;
        out_ready_i <= 1'b0;
        repeat (HoldCycles - 1) @(posedge clk_i);
      end else begin
        if (run_left == 0) begin
          mode     = $urandom_range(0, 2);
          run_left = $urandom_range(10, 80);
        end
        run_left--;
        case (mode)
          0:       out_ready_i <= 1'b1;
          1:       out_ready_i <= 1'($urandom);
          default: out_ready_i <= ($urandom_range(0, 7) == 0);
        endcase
      end
    end
  end

  initial begin
    int kind;
    rst_ni     <= 1'b0;
    in_valid_i <= 1'b0;
    op_i       <= OpQuery;
    sda_i      <= 1'b0;
    scl_i      <= 1'b0;
    now_us_i   <= '0;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_beat(OpPop,   1'b1, 1'b1, 32'h0000_0000);
    send_beat(OpQuery, 1'b0, 1'b0, 32'hFFFF_FFFF);
    send_beat(OpEdge,  1'b1, 1'b1, 32'h0000_0100);
    send_beat(OpStop,  1'b0, 1'b0, 32'h0000_0200);
    send_beat(OpStart, 1'b0, 1'b0, 32'hFFFF_FFF0);
    send_beat(OpEdge,  1'b0, 1'b0, 32'hFFFF_FFF1);
    send_beat(OpEdge,  1'b1, 1'b0, 32'hFFFF_FFFF);
    send_beat(OpEdge,  1'b0, 1'b1, 32'h0000_0000);
    send_beat(OpEdge,  1'b1, 1'b1, 32'h0000_0005);
    send_beat(OpQuery, 1'b1, 1'b1, 32'h0000_0010);
    send_beat(OpPop,   1'b0, 1'b0, 32'h0000_0011);
    send_beat(OpPop,   1'b0, 1'b0, 32'h0000_0012);
    send_beat(OpStop,  1'b0, 1'b0, 32'h0000_0013);
    send_beat(OpEdge,  1'b1, 1'b0, 32'h0000_0014);
    send_beat(OpPop,   1'b0, 1'b0, 32'h0000_0015);
    send_beat(OpPop,   1'b0, 1'b0, 32'h0000_0016);
    send_beat(OpPop,   1'b0, 1'b0, 32'h0000_0017);
    for (int code = OpRsvdLo; code <= OpRsvdHi; code++) begin
      send_beat(3'(code), 1'b1, 1'b1, 32'hFFFF_FFFF);
    end
    send_beat(OpStart, 1'b1, 1'b1, 32'h0000_0000);
    send_beat(OpEdge,  1'b1, 1'b1, 32'hFFFF_FFFF);
    send_beat(OpQuery, 1'b0, 1'b0, 32'h0000_0000);
    send_beat(OpPop,   1'b0, 1'b0, 32'h8000_0000);
    drain();

    while (beats_sent < TargetBeats) begin
      kind = $urandom_range(0, 9);
      if (hold_req < 2 && beats_sent > (hold_req + 1) * 400) begin
        hold_req++;
        burst_left = 150;
        fill_session();
      end else if (kind < 2) begin
        fill_session();
      end else if (kind < 8) begin
        mixed_session(1'b1);
      end else begin
        mixed_session(1'b0);
      end
      if ($urandom_range(0, 5) == 0) drain();
    end

    drain();
    repeat (TailCycles) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("PASS timestamped_edge_capture_fifo_unit");
    end else begin
      $display("FAIL timestamped_edge_capture_fifo_unit");
    end
    $finish;
  end

  initial begin
    #(TimeoutCycles * 2 * ClkHalf);
    $display("FAIL timestamped_edge_capture_fifo_unit");
    $finish;
  end

endmodule
